FILE: design/button_debounce_long_press_core_macros.svh
// Assertion macros used by the press FSM of the debounce core RTL.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_CORE_MACROS_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted
`define BDLP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define BDLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define BDLP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BDLP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/bdlp_pkg.sv
package bdlp_pkg;

	// Counter and register widths
	localparam int CNT_W = 16;
	localparam int ST_W  = 2;

	// Configuration register indexes
	localparam logic REG_QUIET = 1'b0;
	localparam logic REG_HOLD  = 1'b1;

	// Register reset values
	localparam logic [CNT_W-1:0] QUIET_RST = 16'd30;
	localparam logic [CNT_W-1:0] HOLD_RST  = 16'd5000;

	// Press state codes
	localparam logic [ST_W-1:0] ST_IDLE    = 2'd0;
	localparam logic [ST_W-1:0] ST_PRESSED = 2'd1;
	localparam logic [ST_W-1:0] ST_LONG    = 2'd2;

	// Debounced sample handed from the debouncer to the press FSM
	typedef struct packed {
		logic sample;   // quiet period ran out on this item
		logic level;    // level seen on this item
	} sample_t;

	// A register value of zero acts as one
	function automatic logic [CNT_W-1:0] at_least_one(input logic [CNT_W-1:0] v);
		return (v == '0) ? CNT_W'(1) : v;
	endfunction

endpackage

FILE: design/button_debounce_long_press_core.sv
// Button debounce and long-press detector. One raw button level is taken per
// item and one result (short_press, hold_pulse, press_state) comes out per
// item, in order. A new item is accepted every clock cycle while the result
// side keeps up. Each item waits in the input register and is evaluated as
// it moves into the result register, held back while a result waits. The
// press state advances as each item passes from the input register to the
// result register. quiet_ticks (index 0) and hold_ticks (index 1) are
// written through cfg_we/cfg_index/cfg_data; the user must write them only
// while the block is idle; the block does not enforce it. Zero acts as one.
module button_debounce_long_press_core
	import bdlp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CNT_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             raw_level,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             short_press,
	output logic             hold_pulse,
	output logic [ST_W-1:0]  press_state
);

	logic [CNT_W-1:0] quiet_ticks_q;
	logic [CNT_W-1:0] hold_ticks_q;
	logic             valid_s1;
	logic             level_s1;
	logic             out_valid_q;
	logic             short_q;
	logic             long_q;
	logic [ST_W-1:0]  state_out_q;
	logic             advance;
	logic             step;
	sample_t          smp;
	logic             short_d;
	logic             long_d;
	logic [ST_W-1:0]  state_d;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_ticks_q <= QUIET_RST;
			hold_ticks_q  <= HOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_QUIET: quiet_ticks_q <= cfg_data;
				REG_HOLD:  hold_ticks_q  <= cfg_data;
				default:   quiet_ticks_q <= quiet_ticks_q;
			endcase
		end
	end

	// Handshake: result register frees up or is empty
	assign advance  = !out_valid_q || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			level_s1 <= raw_level;
		end
	end

	bdlp_debounce u_debounce (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.level       (level_s1),
		.quiet_ticks (quiet_ticks_q),
		.smp         (smp)
	);

	bdlp_press_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.smp        (smp),
		.hold_ticks (hold_ticks_q),
		.short_o    (short_d),
		.long_o     (long_d),
		.state_o    (state_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			short_q     <= short_d;
			long_q      <= long_d;
			state_out_q <= state_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign short_press = short_q;
	assign hold_pulse  = long_q;
	assign press_state = state_out_q;

endmodule

FILE: design/bdlp_debounce.sv
module bdlp_debounce
	import bdlp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             level,
	input  logic [CNT_W-1:0] quiet_ticks,
	output sample_t          smp
);

	logic             last_q;
	logic [CNT_W-1:0] quiet_q;
	logic [CNT_W-1:0] quiet_d;
	logic             lvl_edge;

	// Edge reloads the quiet counter, otherwise count down to the sample point
	always_comb begin
		lvl_edge   = (level != last_q);
		quiet_d    = quiet_q;
		smp.sample = 1'b0;
		smp.level  = level;
		if (lvl_edge) begin
			quiet_d = at_least_one(quiet_ticks);
		end else if (quiet_q != '0) begin
			quiet_d    = quiet_q - CNT_W'(1);
			smp.sample = (quiet_q == CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= 1'b0;
			quiet_q <= '0;
		end else if (step) begin
			last_q  <= level;
			quiet_q <= quiet_d;
		end
	end

endmodule

FILE: design/bdlp_press_fsm.sv
`include "button_debounce_long_press_core_macros.svh"

module bdlp_press_fsm
	import bdlp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  sample_t          smp,
	input  logic [CNT_W-1:0] hold_ticks,
	output logic             short_o,
	output logic             long_o,
	output logic [ST_W-1:0]  state_o
);

	logic [ST_W-1:0]  state_q;
	logic [ST_W-1:0]  state_mid;
	logic [ST_W-1:0]  state_d;
	logic [CNT_W-1:0] hold_q;
	logic [CNT_W-1:0] hold_mid;
	logic [CNT_W-1:0] hold_d;
	logic             loaded;

	// Debounced sample steps the state, then the hold counter runs
	always_comb begin
		state_mid = state_q;
		hold_mid  = hold_q;
		loaded    = 1'b0;
		short_o   = 1'b0;
		long_o    = 1'b0;
		if (smp.sample) begin
			case (state_q)
				ST_IDLE: begin
					if (smp.level) begin
						state_mid = ST_PRESSED;
						hold_mid  = at_least_one(hold_ticks);
						loaded    = 1'b1;
					end
				end
				ST_PRESSED: begin
					if (!smp.level) begin
						state_mid = ST_IDLE;
						hold_mid  = '0;
						short_o   = 1'b1;
					end
				end
				ST_LONG: begin
					if (!smp.level) begin
						state_mid = ST_IDLE;
					end
				end
				default: begin
					state_mid = state_q;
				end
			endcase
		end

		state_d = state_mid;
		hold_d  = hold_mid;
		if (!loaded && hold_mid != '0) begin
			hold_d = hold_mid - CNT_W'(1);
			if (hold_mid == CNT_W'(1) && state_mid == ST_PRESSED) begin
				state_d = ST_LONG;
				long_o  = 1'b1;
			end
		end
		state_o = state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hold_q  <= '0;
		end else if (step) begin
			state_q <= state_d;
			hold_q  <= hold_d;
		end
	end

	// Pulses are exclusive; hold counter only runs while pressed
	`BDLP_ASSERT_IMPL(a_pulse_excl, clk, arst_n, step, !(short_o && long_o))
	`BDLP_ASSERT_NEXT(a_long_enters, clk, arst_n, step && long_o, state_q == ST_LONG)
	`BDLP_ASSERT_NEXT(a_short_idle, clk, arst_n, step && short_o, state_q == ST_IDLE && hold_q == '0)
	`BDLP_ASSERT_IMPL(a_hold_idle, clk, arst_n, state_q != ST_PRESSED, hold_q == '0)

endmodule
